// ===== rtl/assert_macros.svh =====
// assertion macros shared by cmpk_core and the top level
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== rtl/cmpk_pkg.sv =====
// types and constants for the charge mode power key sequencer
// no dependencies
`timescale 1ns / 1ps

package cmpk_pkg;

   // opcodes
   localparam logic OP_KEY   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // actions
   localparam logic [1:0] ACTION_NONE = 2'd0;
   localparam logic [1:0] ACTION_BOOT = 2'd1;
   localparam logic [1:0] ACTION_OFF  = 2'd2;

   // input event and key codes
   localparam logic [4:0] EVENT_KEY   = 5'd1;
   localparam logic [9:0] KEY_PWR     = 10'd116;
   localparam logic [9:0] KEY_VOLUP   = 10'd115;
   localparam logic [9:0] KEY_VOLDN   = 10'd114;
   localparam logic [1:0] KVAL_RELEASE = 2'd0;
   localparam logic [1:0] KVAL_PRESS   = 2'd1;

   // supply status codes
   localparam logic [2:0] STATUS_CHARGING = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;

   localparam logic [7:0] FULL_PERCENT = 8'd100;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TIME   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_TIME = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNPLUG_TIME = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PERCENT = 4'd3;

   // register reset values
   localparam logic [15:0] RST_HOLD_TIME   = 16'd1500;
   localparam logic [21:0] RST_SCREEN_TIME = 22'd30000;
   localparam logic [15:0] RST_UNPLUG_TIME = 16'd6000;
   localparam logic [6:0]  RST_MIN_PERCENT = 7'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] time_ms;
      logic [4:0]  event_type;
      logic [9:0]  key_code;
      logic [1:0]  key_value;
      logic [7:0]  battery_percent;
      logic [2:0]  supply_status;
      logic        charger_present;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic       screen_lit;
      logic       panel_switch;
      logic       redraw;
      logic [7:0] gauge_percent;
      logic       show_full;
      logic       show_charging;
   } rsp_type;

   typedef struct packed {
      logic [15:0] hold_time_ms;
      logic [21:0] screen_timeout_ms;
      logic [15:0] unplug_timeout_ms;
      logic [6:0]  min_boot_percent;
   } cfg_type;

endpackage

// ===== rtl/cmpk_csr.sv =====
// configuration registers of the sequencer
// depends on cmpk_pkg
`timescale 1ns / 1ps

module cmpk_csr
   import cmpk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // register select
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HOLD_TIME:   cfg_in.hold_time_ms      = csr_wdata[15:0];
            CSR_SCREEN_TIME: cfg_in.screen_timeout_ms = csr_wdata[21:0];
            CSR_UNPLUG_TIME: cfg_in.unplug_timeout_ms = csr_wdata[15:0];
            CSR_MIN_PERCENT: cfg_in.min_boot_percent  = csr_wdata[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time_ms      <= RST_HOLD_TIME;
         cfg_ff.screen_timeout_ms <= RST_SCREEN_TIME;
         cfg_ff.unplug_timeout_ms <= RST_UNPLUG_TIME;
         cfg_ff.min_boot_percent  <= RST_MIN_PERCENT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/cmpk_core.sv =====
// sequencer state and the per-item decision logic
// depends on cmpk_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmpk_core
   import cmpk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic        halted_ff, halted_in;
   logic        lit_ff, lit_in;
   logic [31:0] last_key_time_ff, last_key_time_in;
   logic        press_pending_ff, press_pending_in;
   logic [31:0] press_time_ff, press_time_in;
   logic        unplug_pending_ff, unplug_pending_in;
   logic [31:0] unplug_time_ff, unplug_time_in;
   logic        shown_valid_ff, shown_valid_in;
   logic        shown_lit_ff, shown_lit_in;
   logic [7:0]  drawn_percent_ff, drawn_percent_in;
   logic        drawn_full_ff, drawn_full_in;
   logic [2:0]  drawn_status_ff, drawn_status_in;
   logic        drawn_valid_ff, drawn_valid_in;

   logic        known_key;
   logic        full;
   logic [31:0] unplug_base;
   logic        hold_done, unplug_done, screen_done;
   logic        lit_after;
   logic        changed;

   // elapsed-time compares, all modulo 2^32
   always_comb begin
      unplug_base = unplug_pending_ff ? unplug_time_ff : req.time_ms;
      hold_done   = (req.time_ms - press_time_ff) >= {16'd0, cfg.hold_time_ms};
      unplug_done = (req.time_ms - unplug_base) >= {16'd0, cfg.unplug_timeout_ms};
      screen_done = (req.time_ms - last_key_time_ff) >= {10'd0, cfg.screen_timeout_ms};
      full        = (req.battery_percent >= FULL_PERCENT) ||
                    (req.supply_status == STATUS_FULL);
      known_key   = (req.key_code == KEY_PWR) || (req.key_code == KEY_VOLUP) ||
                    (req.key_code == KEY_VOLDN);
      lit_after   = lit_ff & ~screen_done;
      changed     = ~shown_valid_ff | (lit_after != shown_lit_ff);
   end

   // next state and result
   always_comb begin
      halted_in         = halted_ff;
      lit_in            = lit_ff;
      last_key_time_in  = last_key_time_ff;
      press_pending_in  = press_pending_ff;
      press_time_in     = press_time_ff;
      unplug_pending_in = unplug_pending_ff;
      unplug_time_in    = unplug_time_ff;
      shown_valid_in    = shown_valid_ff;
      shown_lit_in      = shown_lit_ff;
      drawn_percent_in  = drawn_percent_ff;
      drawn_full_in     = drawn_full_ff;
      drawn_status_in   = drawn_status_ff;
      drawn_valid_in    = drawn_valid_ff;
      rsp               = '0;
      rsp.action        = ACTION_NONE;

      if (!halted_ff) begin
         if (req.opcode == OP_KEY) begin
            // key event
            if (req.event_type == EVENT_KEY && known_key) begin
               if (req.key_value == KVAL_PRESS) begin
                  last_key_time_in = req.time_ms;
                  lit_in           = 1'b1;
                  if (req.key_code == KEY_PWR) begin
                     press_pending_in = 1'b1;
                     press_time_in    = req.time_ms;
                  end
               end else if (req.key_value == KVAL_RELEASE &&
                            req.key_code == KEY_PWR) begin
                  press_pending_in = 1'b0;
                  last_key_time_in = req.time_ms;
               end
            end
         end else if (press_pending_ff && lit_ff && hold_done &&
                      req.battery_percent >= {1'b0, cfg.min_boot_percent}) begin
            // boot decision, panel forced on
            rsp.action       = ACTION_BOOT;
            rsp.panel_switch = 1'b1;
            lit_in           = 1'b1;
            halted_in        = 1'b1;
         end else begin
            // charger absence tracking
            if (!req.charger_present) begin
               unplug_pending_in = 1'b1;
               unplug_time_in    = unplug_base;
            end else begin
               unplug_pending_in = 1'b0;
            end
            if (!req.charger_present && unplug_done) begin
               rsp.action = ACTION_OFF;
               halted_in  = 1'b1;
            end else begin
               // screen timeout, redraw and panel switch
               lit_in = lit_after;
               if (lit_after && (changed || !drawn_valid_ff ||
                                 req.battery_percent != drawn_percent_ff ||
                                 full != drawn_full_ff ||
                                 req.supply_status != drawn_status_ff)) begin
                  rsp.redraw        = 1'b1;
                  rsp.gauge_percent = req.battery_percent;
                  rsp.show_full     = full;
                  rsp.show_charging = (req.supply_status == STATUS_CHARGING);
                  drawn_percent_in  = req.battery_percent;
                  drawn_full_in     = full;
                  drawn_status_in   = req.supply_status;
                  drawn_valid_in    = 1'b1;
               end
               if (changed) begin
                  rsp.panel_switch = 1'b1;
                  shown_lit_in     = lit_after;
                  shown_valid_in   = 1'b1;
               end
            end
         end
      end
      rsp.screen_lit = lit_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff         <= 1'b0;
         lit_ff            <= 1'b1;
         press_pending_ff  <= 1'b0;
         unplug_pending_ff <= 1'b0;
         shown_valid_ff    <= 1'b0;
         shown_lit_ff      <= 1'b0;
         drawn_valid_ff    <= 1'b0;
         last_key_time_ff  <= '0;
         press_time_ff     <= '0;
         unplug_time_ff    <= '0;
         drawn_percent_ff  <= '0;
         drawn_full_ff     <= 1'b0;
         drawn_status_ff   <= '0;
      end else if (fire) begin
         halted_ff         <= halted_in;
         lit_ff            <= lit_in;
         press_pending_ff  <= press_pending_in;
         unplug_pending_ff <= unplug_pending_in;
         shown_valid_ff    <= shown_valid_in;
         shown_lit_ff      <= shown_lit_in;
         drawn_valid_ff    <= drawn_valid_in;
         last_key_time_ff  <= last_key_time_in;
         press_time_ff     <= press_time_in;
         unplug_time_ff    <= unplug_time_in;
         drawn_percent_ff  <= drawn_percent_in;
         drawn_full_ff     <= drawn_full_in;
         drawn_status_ff   <= drawn_status_in;
      end
   end

   // checks
   `ASSERT_IMPLIES(a_halted_quiet, clock, reset, fire && halted_ff,
                   rsp.action == ACTION_NONE && !rsp.panel_switch && !rsp.redraw)
   `ASSERT_NEXT(a_action_halts, clock, reset, fire && rsp.action != ACTION_NONE,
                halted_ff)
   `ASSERT_IMPLIES(a_boot_lit, clock, reset, fire && rsp.action == ACTION_BOOT,
                   rsp.screen_lit && rsp.panel_switch && !rsp.redraw)
   `ASSERT_IMPLIES(a_redraw_lit, clock, reset, fire && rsp.redraw, rsp.screen_lit)

endmodule

// ===== rtl/charge_mode_power_key_sequencer.sv =====
// top level of the charge mode power key sequencer
// depends on cmpk_pkg, cmpk_csr, cmpk_core and assert_macros.svh
//
// usage:
//   req_ carries key events and periodic checks (req_data), one transfer
//   when req_valid is high and req_stall is low. rsp_ returns exactly one
//   result per item, in order, under the same valid/stall rule.
//   csr_ writes a configuration register by index; csr_ready is always high.
//   Registers are to be written only while no item is in flight; not enforced.
// flow:
//   an item lands in the input register, is decided by the core
//   compare/update logic once the output stage is free and is written to
//   the result register. One item per cycle is sustained while rsp_stall
//   stays low.
// reset:
//   synchronous, active high; both stages empty, configuration back to its
//   defaults, screen lit, nothing pending, not halted.
// stall:
//   a stalled result holds in the result register; the input register still
//   takes one more item, and req_stall rises only when both stages are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module charge_mode_power_key_sequencer
   import cmpk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type core_rsp;
   logic    out_free;
   logic    fire;
   logic    req_take;

   cmpk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cmpk_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   // stage handshake
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & rsp_stall);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   `ASSERT_NEXT(a_held_item_stays, clock, reset, in_valid_ff && !out_free, in_valid_ff)
   `ASSERT_NEXT(a_fire_fills_output, clock, reset, fire, out_valid_ff)
   `ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall,
                   in_valid_ff && out_valid_ff)

endmodule
